// ===== rtl/scs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, character codes and the segment table for the serial
// command seven-segment scanner.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_C  = 8'h43;
  localparam logic [7:0] CH_K  = 8'h4B;
  localparam logic [7:0] CH_N  = 8'h4E;
  localparam logic [7:0] CH_O  = 8'h4F;

  localparam logic [3:0] CODE_BLANK = 4'd10;

  // result kinds carried on out_tuser
  localparam logic KIND_DISPLAY = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  // command sequencer status toward the top-level control
  typedef struct packed {
    logic done;
    logic ok;
  } cmd_status_t;

  // active-low segment patterns, codes 10..15 are blank
  function automatic logic [7:0] seg_lut(input logic [3:0] code);
    logic [7:0] s;
    unique case (code)
      4'd0:    s = 8'b11000000;
      4'd1:    s = 8'b11111001;
      4'd2:    s = 8'b10100100;
      4'd3:    s = 8'b10110000;
      4'd4:    s = 8'b10011001;
      4'd5:    s = 8'b10010010;
      4'd6:    s = 8'b10000010;
      4'd7:    s = 8'b11111000;
      4'd8:    s = 8'b10000000;
      4'd9:    s = 8'b10011000;
      default: s = 8'b11111111;
    endcase
    return s;
  endfunction

  // reply string O, K, CR, LF
  function automatic logic [7:0] reply_char(input logic [1:0] k);
    logic [7:0] c;
    unique case (k)
      2'd0:    c = CH_O;
      2'd1:    c = CH_K;
      2'd2:    c = CH_CR;
      default: c = CH_LF;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/scs_digit_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_digit_store
// Display digit registers, scan position and segment decode.
// ----------------------------------------------------------------------------
module scs_digit_store #(
  parameter int DIGIT_COUNT = 8,
  localparam int DIG_IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              blank_all,
  input  wire logic              wr_en,
  input  wire logic [DIG_IW-1:0] wr_idx,
  input  wire logic [3:0]        wr_code,
  input  wire logic              scan_adv,
  output logic [7:0]             segments,
  output logic [7:0]             digit_select
);

  logic [3:0]        digit_r [DIGIT_COUNT];
  logic [DIG_IW-1:0] pos_r;
  logic [DIG_IW-1:0] pos_nxt;

  always_comb begin
    if (pos_r == DIG_IW'(DIGIT_COUNT - 1)) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        digit_r[i] <= 4'(i);
      end
      pos_r <= '0;
    end else begin
      if (blank_all) begin
        for (int i = 0; i < DIGIT_COUNT; i++) begin
          digit_r[i] <= scs_pkg::CODE_BLANK;
        end
      end else if (wr_en) begin
        digit_r[wr_idx] <= wr_code;
      end
      if (scan_adv) begin
        pos_r <= pos_nxt;
      end
    end
  end

  assign segments     = scs_pkg::seg_lut(digit_r[pos_r]);
  assign digit_select = 8'(1) << pos_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= DIG_IW'(DIGIT_COUNT - 1))
    else $error("scan position out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/scs_cmd_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scs_cmd_seq
// Command buffer and the sequencer that decodes a finished line. One byte
// compare unit walks the buffer: forward to find the last CR, then backward
// to copy digits into the display.
// ----------------------------------------------------------------------------
module scs_cmd_seq #(
  parameter int DIGIT_COUNT  = 8,
  parameter int BUFFER_DEPTH = 12,
  localparam int FW     = $clog2(BUFFER_DEPTH + 1),
  localparam int IW     = $clog2(BUFFER_DEPTH),
  localparam int DIG_IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1,
  localparam int DW     = $clog2(DIGIT_COUNT + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [7:0]        wr_byte,
  input  wire logic              start,
  output scs_pkg::cmd_status_t   status,
  output logic                   dig_blank,
  output logic                   dig_we,
  output logic [DIG_IW-1:0]      dig_idx,
  output logic [3:0]             dig_code
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_DEC  = 2'd1;
  localparam logic [1:0] C_SEEK = 2'd2;
  localparam logic [1:0] C_LOAD = 2'd3;

  logic [1:0]    st_r, st_nxt;
  logic [7:0]    cbuf_r [BUFFER_DEPTH];
  logic [FW-1:0] fill_r;
  logic [FW-1:0] idx_r;
  logic [FW-1:0] end_r;
  logic [FW-1:0] ptr_r;
  logic [DW-1:0] d_r;

  // shared compare unit
  logic [FW-1:0] rd_idx;
  logic [7:0]    rd_byte;
  logic [7:0]    cmd_byte;
  logic          is_cr, is_n, is_dig;
  logic          has_cmd;
  logic          load_go;

  assign rd_idx   = (st_r == C_SEEK) ? idx_r : ptr_r;
  assign rd_byte  = cbuf_r[rd_idx[IW-1:0]];
  assign cmd_byte = cbuf_r[0];
  assign is_cr    = (rd_byte == scs_pkg::CH_CR);
  assign is_n     = (rd_byte == scs_pkg::CH_N);
  assign is_dig   = (rd_byte >= scs_pkg::CH_0) && (rd_byte <= scs_pkg::CH_9);
  assign has_cmd  = (fill_r != '0);
  assign load_go  = (ptr_r != '0) && (d_r < DW'(DIGIT_COUNT)) && !is_n;

  assign dig_idx  = d_r[DIG_IW-1:0];
  assign dig_code = is_dig ? 4'(rd_byte - scs_pkg::CH_0) : scs_pkg::CODE_BLANK;

  always_comb begin
    st_nxt    = st_r;
    status    = '0;
    dig_blank = 1'b0;
    dig_we    = 1'b0;
    unique case (st_r)
      C_IDLE: begin
        if (start) st_nxt = C_DEC;
      end
      C_DEC: begin
        if (has_cmd && cmd_byte == scs_pkg::CH_N) begin
          dig_blank = 1'b1;
          st_nxt    = C_SEEK;
        end else begin
          status.done = 1'b1;
          status.ok   = has_cmd && (cmd_byte == scs_pkg::CH_C ||
                                    cmd_byte == scs_pkg::CH_A);
          dig_blank   = has_cmd && (cmd_byte == scs_pkg::CH_C);
          st_nxt      = C_IDLE;
        end
      end
      C_SEEK: begin
        if (idx_r >= fill_r) st_nxt = C_LOAD;
      end
      C_LOAD: begin
        if (load_go) begin
          dig_we = 1'b1;
        end else begin
          status.done = 1'b1;
          status.ok   = 1'b1;
          st_nxt      = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      fill_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (status.done) begin
        fill_r <= '0;
      end else if (st_r == C_IDLE && wr_en && fill_r < FW'(BUFFER_DEPTH)) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  // payload: buffer contents and walk pointers
  always_ff @(posedge clk) begin
    if (st_r == C_IDLE && wr_en && fill_r < FW'(BUFFER_DEPTH)) begin
      cbuf_r[fill_r[IW-1:0]] <= wr_byte;
    end
    unique case (st_r)
      C_DEC: begin
        idx_r <= FW'(1);
        end_r <= fill_r;
      end
      C_SEEK: begin
        if (idx_r < fill_r) begin
          if (is_cr) end_r <= idx_r;
          idx_r <= idx_r + 1'b1;
        end else begin
          ptr_r <= end_r - 1'b1;
          d_r   <= '0;
        end
      end
      C_LOAD: begin
        if (dig_we) begin
          ptr_r <= ptr_r - 1'b1;
          d_r   <= d_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUFFER_DEPTH))
    else $error("command buffer fill exceeds depth");
  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    status.done |=> fill_r == '0 && st_r == C_IDLE)
    else $error("buffer not cleared after command");
`endif

endmodule
`default_nettype wire

// ===== rtl/serial_command_seven_segment_scanner_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_seven_segment_scanner_top
// Serial command decoder driving a multiplexed seven-segment display.
// ----------------------------------------------------------------------------
// A request with in_tuser = 0 is a received serial byte; bytes are buffered
// until LF, which runs the command ('N' load digits, 'C' clear, 'A' ping)
// and returns O, K, CR, LF as four reply results (out_tuser = 1). A request
// with in_tuser = 1 is a scan tick and returns one display result with the
// segment pattern and one-hot select of the current scan digit, then advances
// the scan position. An LF keeps the input blocked while one byte compare
// unit walks the buffer and until the reply bytes have been loaded into the
// output register, which waits for out_tready.
// A pending result in the output register does not block the next request.
// ----------------------------------------------------------------------------
module serial_command_seven_segment_scanner_top #(
  parameter int DIGIT_COUNT  = 8,
  parameter int BUFFER_DEPTH = 12
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic        in_tuser,   // [0] mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] segments, [15:8] digit_select, [23:16] tx_byte
  output logic             out_tuser,  // [0] kind
  output logic             out_tlast
);

  localparam int DIG_IW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TICK  = 2'd1;
  localparam logic [1:0] S_CMD   = 2'd2;
  localparam logic [1:0] S_REPLY = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [1:0]  k_r;
  logic        out_valid_r;
  logic [23:0] out_data_r;
  logic        out_kind_r;
  logic        out_last_r;

  logic        in_acc;
  logic        slot_free;
  logic        load_tick;
  logic        load_reply;
  logic        cmd_start;
  logic        cmd_wr;

  scs_pkg::cmd_status_t cmd_st;
  logic              dig_blank;
  logic              dig_we;
  logic [DIG_IW-1:0] dig_idx;
  logic [3:0]        dig_code;
  logic [7:0]        seg;
  logic [7:0]        sel;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign load_tick  = (state_r == S_TICK) && slot_free;
  assign load_reply = (state_r == S_REPLY) && slot_free;
  assign cmd_start  = in_acc && !in_tuser && (in_tdata == scs_pkg::CH_LF);
  assign cmd_wr     = in_acc && !in_tuser && (in_tdata != scs_pkg::CH_LF);

  scs_cmd_seq #(
    .DIGIT_COUNT  (DIGIT_COUNT),
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_cmd (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (cmd_wr),
    .wr_byte   (in_tdata),
    .start     (cmd_start),
    .status    (cmd_st),
    .dig_blank (dig_blank),
    .dig_we    (dig_we),
    .dig_idx   (dig_idx),
    .dig_code  (dig_code)
  );

  scs_digit_store #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_digits (
    .clk          (clk),
    .rst_n        (rst_n),
    .blank_all    (dig_blank),
    .wr_en        (dig_we),
    .wr_idx       (dig_idx),
    .wr_code      (dig_code),
    .scan_adv     (load_tick),
    .segments     (seg),
    .digit_select (sel)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser) state_nxt = S_TICK;
        else if (cmd_start)     state_nxt = S_CMD;
      end
      S_TICK: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_CMD: begin
        if (cmd_st.done) state_nxt = cmd_st.ok ? S_REPLY : S_IDLE;
      end
      S_REPLY: begin
        if (slot_free && k_r == 2'd3) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CMD) begin
        k_r <= '0;
      end else if (load_reply) begin
        k_r <= k_r + 1'b1;
      end
      if (load_tick || load_reply) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_tick) begin
      out_data_r <= {8'h00, sel, seg};
      out_kind_r <= scs_pkg::KIND_DISPLAY;
      out_last_r <= 1'b1;
    end else if (load_reply) begin
      out_data_r <= {scs_pkg::reply_char(k_r), 16'h0000};
      out_kind_r <= scs_pkg::KIND_REPLY;
      out_last_r <= (k_r == 2'd3);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_done_in_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_st.done |-> state_r == S_CMD)
    else $error("command finished outside command state");
  a_reply_last_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tlast |-> out_tdata[23:16] == scs_pkg::CH_LF)
    else $error("last reply byte is not LF");
  a_display_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> $onehot(out_tdata[15:8]) && out_tlast)
    else $error("display result malformed");
`endif

endmodule
`default_nettype wire
